/* hw/rtl/dtr_pkg.sv */
// dtr_pkg: shared widths, codes and controller/datapath interface structs
// for the depth-tested triangle rasterizer. No dependencies.
package dtr_pkg;

  localparam int COORD_W    = 10;
  localparam int DEPTH_IN_W = 12;
  localparam int TEX_W      = 10;
  localparam int Z_W        = 24;
  localparam int DIFF_W     = 11;
  localparam int PROD_W     = 22;
  localparam int W_W        = 23;
  localparam int DEN_W      = 22;
  localparam int ATTR_W     = 13;
  localparam int MUL_W      = 36;
  localparam int ACC_W      = 38;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam logic [1:0] SLOT_LAST  = 2'd2;
  localparam logic [1:0] KIND_DEPTH = 2'd0;
  localparam logic [1:0] KIND_U     = 2'd1;
  localparam logic [1:0] KIND_V     = 2'd2;

  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};
  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};

  typedef struct packed {
    logic       clr_en;
    logic       load_en;
    logic       start_en;
    logic       prod_en;
    logic       edge_en;
    logic       mac_en;
    logic       mac_first;
    logic [1:0] mac_k;
    logic [1:0] kind;
    logic       div_start;
    logic       cmp_en;
    logic       u_cap;
    logic       v_cap;
    logic       emit_en;
  } dtr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic active;
    logic in_tri;
    logic nearer;
    logic div_done;
    logic div_busy;
    logic out_free;
  } dtr_stat_t;

endpackage

/* hw/rtl/dtr_div.sv */
// dtr_div: iterative restoring divider, one quotient bit per cycle.
// Unsigned operands; depends on nothing.
module dtr_div #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             busy,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, work_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CNT_W'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // Shift quotient bits in as numerator bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= num;
      rem_r  <= '0;
      den_r  <= den;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      work_r <= {work_r[NUM_W-2:0], ge};
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  assign quo  = work_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

/* hw/rtl/dtr_datapath.sv */
// dtr_datapath: corner registers, walk cursor, edge weights, shared MAC and
// divider, depth store and output register. Uses dtr_pkg and dtr_div.
module dtr_datapath #(
  parameter int SCREEN_WIDTH    = 1024,
  parameter int SCREEN_HEIGHT   = 1024,
  parameter int DEPTH_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dtr_pkg::dtr_cmd_t                 cmd,
  output dtr_pkg::dtr_stat_t                stat,
  input  logic [1:0]                        in_vertex_slot,
  input  logic [dtr_pkg::COORD_W-1:0]       in_vert_x,
  input  logic [dtr_pkg::COORD_W-1:0]       in_vert_y,
  input  logic signed [dtr_pkg::DEPTH_IN_W-1:0] in_vert_depth,
  input  logic [dtr_pkg::TEX_W-1:0]         in_vert_u,
  input  logic [dtr_pkg::TEX_W-1:0]         in_vert_v,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dtr_pkg::COORD_W-1:0]       out_pixel_x,
  output logic [dtr_pkg::COORD_W-1:0]       out_pixel_y,
  output logic [dtr_pkg::TEX_W-1:0]         out_tex_u_out,
  output logic [dtr_pkg::TEX_W-1:0]         out_tex_v_out,
  output logic                              out_drawn,
  output logic                              out_final_candidate
);
  import dtr_pkg::*;

  localparam int NPIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(NPIX);
  localparam int NUM_W  = ACC_W - 1 + DEPTH_FRAC_BITS;
  localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(1) << (Z_W - 1);
  localparam logic [NUM_W-1:0] Q_POS_LIM = Q_NEG_LIM - NUM_W'(1);

  // Corner registers
  logic [COORD_W-1:0]           cx_r [3];
  logic [COORD_W-1:0]           cy_r [3];
  logic signed [DEPTH_IN_W-1:0] cd_r [3];
  logic [TEX_W-1:0]             cu_r [3];
  logic [TEX_W-1:0]             cv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
        cd_r[i] <= '0;
        cu_r[i] <= '0;
        cv_r[i] <= '0;
      end
    end else if (cmd.load_en) begin
      for (int i = 0; i < 3; i++) begin
        if (in_vertex_slot == 2'(i)) begin
          cx_r[i] <= in_vert_x;
          cy_r[i] <= in_vert_y;
          cd_r[i] <= in_vert_depth;
          cu_r[i] <= in_vert_u;
          cv_r[i] <= in_vert_v;
        end
      end
    end
  end

  // Bounding box of the loaded corners
  logic [COORD_W-1:0] bx_min, bx_max, by_min, by_max;

  always_comb begin
    bx_min = cx_r[0];
    bx_max = cx_r[0];
    by_min = cy_r[0];
    by_max = cy_r[0];
    for (int i = 1; i < 3; i++) begin
      if (cx_r[i] < bx_min) bx_min = cx_r[i];
      if (cx_r[i] > bx_max) bx_max = cx_r[i];
      if (cy_r[i] < by_min) by_min = cy_r[i];
      if (cy_r[i] > by_max) by_max = cy_r[i];
    end
  end

  // Walk cursor
  logic [COORD_W-1:0] xmin_r, xmax_r, ymin_r;
  logic [COORD_W-1:0] cur_x_r, cur_y_r;
  logic               active_r;
  logic [COORD_W:0]   x_inc;
  logic               final_c;

  assign x_inc   = {1'b0, cur_x_r} + (COORD_W+1)'(1);
  assign final_c = (x_inc == {1'b0, xmax_r}) &&
                   ({1'b0, cur_y_r} == {1'b0, ymin_r} + (COORD_W+1)'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
    end else if (cmd.load_en) begin
      if (in_vertex_slot <= SLOT_LAST) active_r <= 1'b0;
    end else if (cmd.start_en) begin
      cur_x_r  <= bx_min;
      cur_y_r  <= by_max;
      active_r <= (bx_max != bx_min) && (by_max != by_min);
    end else if (cmd.emit_en) begin
      if (final_c) begin
        active_r <= 1'b0;
      end else if (x_inc >= {1'b0, xmax_r}) begin
        cur_x_r <= xmin_r;
        cur_y_r <= cur_y_r - COORD_W'(1);
      end else begin
        cur_x_r <= x_inc[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_en) begin
      xmin_r <= bx_min;
      xmax_r <= bx_max;
      ymin_r <= by_min;
    end
  end

  // Edge-function products
  logic signed [DIFF_W-1:0] ex [3];
  logic signed [DIFF_W-1:0] ey [3];
  logic signed [DIFF_W-1:0] epx, epy;
  logic signed [DIFF_W-1:0] bax, cay, cax, bay, bpx, cpy, cpx, bpy, pax, pay;
  logic signed [PROD_W-1:0] pr_r [8];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = $signed({1'b0, cx_r[i]});
      ey[i] = $signed({1'b0, cy_r[i]});
    end
  end

  assign epx = $signed({1'b0, cur_x_r});
  assign epy = $signed({1'b0, cur_y_r});
  assign bax = ex[1] - ex[0];
  assign cay = ey[2] - ey[0];
  assign cax = ex[2] - ex[0];
  assign bay = ey[1] - ey[0];
  assign bpx = ex[1] - epx;
  assign cpy = ey[2] - epy;
  assign cpx = ex[2] - epx;
  assign bpy = ey[1] - epy;
  assign pax = epx - ex[0];
  assign pay = epy - ey[0];

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      pr_r[0] <= bax * cay;
      pr_r[1] <= cax * bay;
      pr_r[2] <= bpx * cpy;
      pr_r[3] <= cpx * bpy;
      pr_r[4] <= pax * cay;
      pr_r[5] <= cax * pay;
      pr_r[6] <= bax * pay;
      pr_r[7] <= pax * bay;
    end
  end

  // Weights, sign normalization and inside test
  logic signed [W_W-1:0] det_s;
  logic signed [W_W-1:0] det_n;
  logic signed [W_W-1:0] w_s [3];
  logic signed [W_W-1:0] w_n [3];
  logic signed [W_W-1:0] w_r [3];
  logic [DEN_W-1:0]      det_r;
  logic                  inside_r;
  logic                  in_screen;
  logic                  all_pos;

  assign det_s = W_W'(pr_r[0]) - W_W'(pr_r[1]);
  assign det_n = det_s[W_W-1] ? -det_s : det_s;
  assign in_screen = (32'(cur_x_r) < SCREEN_WIDTH) && (32'(cur_y_r) < SCREEN_HEIGHT);

  always_comb begin
    all_pos = 1'b1;
    for (int i = 0; i < 3; i++) begin
      w_s[i] = W_W'(pr_r[2*i+2]) - W_W'(pr_r[2*i+3]);
      w_n[i] = det_s[W_W-1] ? -w_s[i] : w_s[i];
      if (w_n[i][W_W-1]) all_pos = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_en) begin
      det_r    <= det_n[DEN_W-1:0];
      inside_r <= (det_s != '0) && all_pos && in_screen;
      for (int i = 0; i < 3; i++) w_r[i] <= w_n[i];
    end
  end

  // Shared multiply-accumulate over the three corners
  logic signed [ATTR_W-1:0] attr_sel;
  logic signed [W_W-1:0]    w_sel;
  logic signed [MUL_W-1:0]  mul;
  logic signed [ACC_W-1:0]  acc_r;
  logic [1:0]               k_idx;

  assign k_idx = cmd.mac_k;

  always_comb begin
    logic [1:0] kk;
    kk = (k_idx == 2'd0 || k_idx == 2'd1) ? k_idx : 2'd2;
    w_sel = w_r[kk];
    case (cmd.kind)
      KIND_DEPTH: attr_sel = ATTR_W'(cd_r[kk]);
      KIND_U:     attr_sel = $signed({3'b000, cu_r[kk]});
      default:    attr_sel = $signed({3'b000, cv_r[kk]});
    endcase
  end

  assign mul = attr_sel * w_sel;

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc_r <= cmd.mac_first ? ACC_W'(mul) : acc_r + ACC_W'(mul);
    end
  end

  // Divider feed: magnitude, with the fraction shift for depth
  logic [ACC_W-1:0] acc_abs;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] quo;
  logic             div_busy;
  logic             div_done;
  logic             neg_r;

  assign acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign div_num = (cmd.kind == KIND_DEPTH) ?
                   (NUM_W'(acc_abs[ACC_W-2:0]) << DEPTH_FRAC_BITS) :
                   NUM_W'(acc_abs[ACC_W-2:0]);

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg_r <= acc_r[ACC_W-1];
  end

  dtr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det_r),
    .quo   (quo),
    .busy  (div_busy),
    .done  (div_done)
  );

  // Saturate the interpolated depth
  logic signed [Z_W-1:0] z_val;

  always_comb begin
    if (neg_r) begin
      z_val = (quo >= Q_NEG_LIM) ? Z_MIN : -$signed(quo[Z_W-1:0]);
    end else begin
      z_val = (quo > Q_POS_LIM) ? Z_MAX : $signed(quo[Z_W-1:0]);
    end
  end

  // Depth store with clear sweep
  logic [Z_W-1:0]    mem [NPIX];
  logic [Z_W-1:0]    rd_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] pix_idx;
  logic              nearer;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [Z_W-1:0]    mem_wd;

  assign pix_idx = ADDR_W'(cur_y_r) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cur_x_r);
  assign nearer  = z_val > $signed(rd_r);
  assign mem_we  = cmd.clr_en || (cmd.cmp_en && nearer);
  assign mem_wa  = cmd.clr_en ? clr_cnt_r : pix_idx;
  assign mem_wd  = cmd.clr_en ? Z_MIN : z_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.edge_en) rd_r <= mem[pix_idx];
  end

  // Per-candidate results
  logic             drawn_r;
  logic [TEX_W-1:0] tex_u_r, tex_v_r;

  always_ff @(posedge clk) begin
    if (cmd.edge_en) begin
      drawn_r <= 1'b0;
      tex_u_r <= '0;
      tex_v_r <= '0;
    end else begin
      if (cmd.cmp_en && nearer) drawn_r <= 1'b1;
      if (cmd.u_cap) tex_u_r <= quo[TEX_W-1:0];
      if (cmd.v_cap) tex_v_r <= quo[TEX_W-1:0];
    end
  end

  // Output register: hold until the beat is taken
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_pixel_x         <= cur_x_r;
      out_pixel_y         <= cur_y_r;
      out_tex_u_out       <= tex_u_r;
      out_tex_v_out       <= tex_v_r;
      out_drawn           <= drawn_r;
      out_final_candidate <= final_c;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.clr_last = (clr_cnt_r == ADDR_W'(NPIX - 1));
  assign stat.active   = active_r;
  assign stat.in_tri   = inside_r;
  assign stat.nearer   = nearer;
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

/* hw/rtl/dtr_ctrl.sv */
// dtr_ctrl: sequencer for clear sweep, corner loads and candidate evaluation.
// Uses dtr_pkg; drives the datapath through dtr_cmd_t.
module dtr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [1:0]         in_vertex_slot,
  input  dtr_pkg::dtr_stat_t stat,
  output dtr_pkg::dtr_cmd_t  cmd
);
  import dtr_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_PROD  = 4'd3;
  localparam logic [3:0] S_EDGE  = 4'd4;
  localparam logic [3:0] S_TEST  = 4'd5;
  localparam logic [3:0] S_MAC   = 4'd6;
  localparam logic [3:0] S_DIVS  = 4'd7;
  localparam logic [3:0] S_DIVW  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      k_r     <= '0;
      kind_r  <= KIND_DEPTH;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    cmd.mac_k = k_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load_en = 1'b1;
            if (in_vertex_slot == SLOT_LAST) state_nxt = S_START;
          end else if (stat.active) begin
            state_nxt = S_PROD;
          end
        end
      end
      S_START: begin
        cmd.start_en = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_EDGE;
      end
      S_EDGE: begin
        cmd.edge_en = 1'b1;
        state_nxt   = S_TEST;
      end
      S_TEST: begin
        if (stat.in_tri) begin
          state_nxt = S_MAC;
          k_nxt     = 2'd0;
          kind_nxt  = KIND_DEPTH;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MAC: begin
        cmd.mac_en    = 1'b1;
        cmd.mac_first = (k_r == 2'd0);
        if (k_r == 2'd2) begin
          state_nxt = S_DIVS;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          case (kind_r)
            KIND_DEPTH: begin
              cmd.cmp_en = 1'b1;
              if (stat.nearer) begin
                state_nxt = S_MAC;
                k_nxt     = 2'd0;
                kind_nxt  = KIND_U;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            KIND_U: begin
              cmd.u_cap = 1'b1;
              state_nxt = S_MAC;
              k_nxt     = 2'd0;
              kind_nxt  = KIND_V;
            end
            default: begin
              cmd.v_cap = 1'b1;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_en = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/depth_tested_triangle_rasterizer_top.sv */
// Depth-tested triangle rasterizer. Load beat: corner 2 also passes the start
// state. Step beat: with no walk it is taken in idle; outside or degenerate it
// runs product, edge and test states, then emits; inside, each division (depth,
// u, v) runs a MAC pass over the three corners, a start state and a wait for
// done, u and v only when drawn, plus any wait for the output register to free.
// Reset (synchronous, rst_n low) clears control, then sweeps the depth store
// to its minimum, one entry a cycle over all SCREEN_WIDTH*SCREEN_HEIGHT entries.
module depth_tested_triangle_rasterizer_top #(
  parameter int SCREEN_WIDTH    = 1024,
  parameter int SCREEN_HEIGHT   = 1024,
  parameter int DEPTH_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_mode,
  input  logic [1:0]                            in_vertex_slot,
  input  logic [dtr_pkg::COORD_W-1:0]           in_vert_x,
  input  logic [dtr_pkg::COORD_W-1:0]           in_vert_y,
  input  logic signed [dtr_pkg::DEPTH_IN_W-1:0] in_vert_depth,
  input  logic [dtr_pkg::TEX_W-1:0]             in_vert_u,
  input  logic [dtr_pkg::TEX_W-1:0]             in_vert_v,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dtr_pkg::COORD_W-1:0]           out_pixel_x,
  output logic [dtr_pkg::COORD_W-1:0]           out_pixel_y,
  output logic [dtr_pkg::TEX_W-1:0]             out_tex_u_out,
  output logic [dtr_pkg::TEX_W-1:0]             out_tex_v_out,
  output logic                                  out_drawn,
  output logic                                  out_final_candidate
);
  import dtr_pkg::*;

  dtr_cmd_t  cmd;
  dtr_stat_t stat;

  dtr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_vertex_slot (in_vertex_slot),
    .stat           (stat),
    .cmd            (cmd)
  );

  dtr_datapath #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_vertex_slot      (in_vertex_slot),
    .in_vert_x           (in_vert_x),
    .in_vert_y           (in_vert_y),
    .in_vert_depth       (in_vert_depth),
    .in_vert_u           (in_vert_u),
    .in_vert_v           (in_vert_v),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_pixel_x         (out_pixel_x),
    .out_pixel_y         (out_pixel_y),
    .out_tex_u_out       (out_tex_u_out),
    .out_tex_v_out       (out_tex_v_out),
    .out_drawn           (out_drawn),
    .out_final_candidate (out_final_candidate)
  );

  // Texture fields stay zero on beats that did not draw
  a_tex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drawn |-> out_tex_u_out == '0 && out_tex_v_out == '0)
    else $error("texture fields nonzero on undrawn beat");

  // Input is never taken while the divider runs
  a_ready_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.div_busy)
    else $error("input ready while divider busy");

  // An accepted step on an active walk blocks the next input cycle
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_STEP && stat.active |=> !in_ready)
    else $error("input ready right after starting a candidate");

  // Store writes and emits never coincide with the input being ready
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.emit_en && !cmd.cmp_en)
    else $error("datapath update while idle");

endmodule

/* tb/tb.sv */
// Testbench for depth_tested_triangle_rasterizer_top: loads triangles, walks their
// bounding boxes and checks every candidate beat against a behavioral predictor.
// Depends on dtr_pkg and the rasterizer RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtr_pkg::*;

  localparam int SCR_W       = 1024;
  localparam int SCR_H       = 1024;
  localparam int FRAC        = 8;
  localparam logic [1:0] SLOT_UNUSED = 2'd3;
  localparam int NUM_ITEMS   = 950;
  // Reset sweep covers the whole depth store before the first beat.
  localparam int IDLE_LIMIT  = 4_500_000;
  localparam int DRAIN_CYC   = 300;

  typedef struct {
    logic                        mode;
    logic [1:0]                  slot;
    logic [COORD_W-1:0]          x;
    logic [COORD_W-1:0]          y;
    logic signed [DEPTH_IN_W-1:0] d;
    logic [TEX_W-1:0]            u;
    logic [TEX_W-1:0]            v;
  } beat_t;

  typedef struct {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [TEX_W-1:0]   tu;
    logic [TEX_W-1:0]   tv;
    logic               drawn;
    logic               last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_LOAD;
  logic [1:0] in_vertex_slot = '0;
  logic [COORD_W-1:0] in_vert_x = '0, in_vert_y = '0;
  logic signed [DEPTH_IN_W-1:0] in_vert_depth = '0;
  logic [TEX_W-1:0] in_vert_u = '0, in_vert_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COORD_W-1:0] out_pixel_x, out_pixel_y;
  logic [TEX_W-1:0] out_tex_u_out, out_tex_v_out;
  logic out_drawn, out_final_candidate;

  depth_tested_triangle_rasterizer_top u_top (.*);

  always #5 clk = ~clk;

  beat_t  pending_beats[$];
  pixel_t expected_pixels[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     n_in = 0, n_out = 0, n_drawn = 0, n_tri = 0;

  // Rasterizer state mirror
  int corner_x[3], corner_y[3], corner_d[3], corner_u[3], corner_v[3];
  int walk_x, walk_y, box_xmin, box_xmax, box_ymin;
  bit walking;
  int zbuf[int];

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (pixel %0d)", what, got, want, n_out);
    errors++;
  endtask

  // Apply one accepted beat to the mirror; queue the candidate it produces.
  task automatic rasterize_beat(beat_t b);
    longint ax, ay, bx, by, qx, qy, px, py, det, w0, w1, w2, z;
    int s, idx, cur;
    pixel_t p;
    if (b.mode == MODE_LOAD) begin
      if (b.slot == SLOT_UNUSED) return;
      s = int'(b.slot);
      walking = 0;
      corner_x[s] = int'(b.x); corner_y[s] = int'(b.y); corner_d[s] = int'(b.d);
      corner_u[s] = int'(b.u); corner_v[s] = int'(b.v);
      if (b.slot == SLOT_LAST) begin
        box_xmin = corner_x[0]; box_xmax = corner_x[0];
        box_ymin = corner_y[0]; walk_y = corner_y[0];
        for (int i = 1; i < 3; i++) begin
          if (corner_x[i] < box_xmin) box_xmin = corner_x[i];
          if (corner_x[i] > box_xmax) box_xmax = corner_x[i];
          if (corner_y[i] < box_ymin) box_ymin = corner_y[i];
          if (corner_y[i] > walk_y) walk_y = corner_y[i];
        end
        walk_x = box_xmin;
        walking = (box_xmax != box_xmin) && (walk_y != box_ymin);
      end
      return;
    end
    if (!walking) return;
    ax = corner_x[0]; ay = corner_y[0];
    bx = corner_x[1]; by = corner_y[1];
    qx = corner_x[2]; qy = corner_y[2];
    px = walk_x; py = walk_y;
    det = ax * (by - qy) - bx * (ay - qy) + qx * (ay - by);
    w0  = px * (by - qy) - bx * (py - qy) + qx * (py - by);
    w1  = ax * (py - qy) - px * (ay - qy) + qx * (ay - py);
    w2  = ax * (by - py) - bx * (ay - py) + px * (ay - by);
    if (det < 0) begin
      det = -det; w0 = -w0; w1 = -w1; w2 = -w2;
    end
    p.px = COORD_W'(walk_x); p.py = COORD_W'(walk_y);
    p.tu = '0; p.tv = '0; p.drawn = 0;
    if (det != 0 && w0 >= 0 && w1 >= 0 && w2 >= 0 && walk_x < SCR_W && walk_y < SCR_H) begin
      z = ((corner_d[0] * w0 + corner_d[1] * w1 + corner_d[2] * w2) * (64'sd1 << FRAC)) / det;
      if (z < -(64'sd1 << 23)) z = -(64'sd1 << 23);
      if (z > (64'sd1 << 23) - 1) z = (64'sd1 << 23) - 1;
      idx = walk_y * SCR_W + walk_x;
      cur = zbuf.exists(idx) ? zbuf[idx] : -(1 << 23);
      if (z > cur) begin
        zbuf[idx] = int'(z);
        p.drawn = 1;
        p.tu = TEX_W'((corner_u[0] * w0 + corner_u[1] * w1 + corner_u[2] * w2) / det);
        p.tv = TEX_W'((corner_v[0] * w0 + corner_v[1] * w1 + corner_v[2] * w2) / det);
      end
    end
    p.last = (walk_x == box_xmax - 1) && (walk_y == box_ymin + 1);
    if (p.last) walking = 0;
    else begin
      walk_x++;
      if (walk_x >= box_xmax) begin
        walk_x = box_xmin;
        walk_y--;
      end
    end
    expected_pixels.push_back(p);
  endtask

  // Sender: bursts of beats separated by random gaps
  int burst_left = 1, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pending_beats.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        beat_t b;
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_mode <= b.mode; in_vertex_slot <= b.slot;
        in_vert_x <= b.x; in_vert_y <= b.y; in_vert_depth <= b.d;
        in_vert_u <= b.u; in_vert_v <= b.v;
        if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: stall style rotates among always ready, random, periodic and mostly ready
  int rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 700) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ((rx_cycle % 7) < 2);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Monitor both channels; predict on input, compare on output
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        beat_t b;
        b.mode = in_mode; b.slot = in_vertex_slot; b.x = in_vert_x; b.y = in_vert_y;
        b.d = in_vert_depth; b.u = in_vert_u; b.v = in_vert_v;
        rasterize_beat(b);
        n_in++;
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (expected_pixels.size() == 0) begin
          $display("MISMATCH unexpected pixel beat x=%0d y=%0d", out_pixel_x, out_pixel_y);
          errors++;
        end else begin
          pixel_t e;
          e = expected_pixels.pop_front();
          if (out_pixel_x !== e.px) report("pixel_x", out_pixel_x, e.px);
          if (out_pixel_y !== e.py) report("pixel_y", out_pixel_y, e.py);
          if (out_tex_u_out !== e.tu) report("tex_u", out_tex_u_out, e.tu);
          if (out_tex_v_out !== e.tv) report("tex_v", out_tex_v_out, e.tv);
          if (out_drawn !== e.drawn) report("drawn", out_drawn, e.drawn);
          if (out_final_candidate !== e.last) report("final", out_final_candidate, e.last);
          if (e.drawn) n_drawn++;
        end
        n_out++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_load(int slot, int x, int y, int d, int u, int v);
    beat_t b;
    b.mode = MODE_LOAD; b.slot = 2'(slot); b.x = COORD_W'(x); b.y = COORD_W'(y);
    b.d = DEPTH_IN_W'(d); b.u = TEX_W'(u); b.v = TEX_W'(v);
    pending_beats.push_back(b);
  endtask

  task automatic add_steps(int n);
    beat_t b;
    b.mode = MODE_STEP; b.slot = 2'($urandom); b.x = COORD_W'($urandom);
    b.y = COORD_W'($urandom); b.d = DEPTH_IN_W'($urandom);
    b.u = TEX_W'($urandom); b.v = TEX_W'($urandom);
    repeat (n) pending_beats.push_back(b);
  endtask

  // Random triangle in a small box; overlaps come from a few shared anchors
  task automatic add_triangle();
    int bx, by, xs[3], ys[3], w, h, n;
    if ($urandom_range(0, 9) < 6) begin
      bx = ($urandom_range(0, 3)) * 250 + 5; by = ($urandom_range(0, 3)) * 250 + 5;
    end else begin
      bx = $urandom_range(0, 1017); by = $urandom_range(0, 1017);
    end
    for (int i = 0; i < 3; i++) begin
      xs[i] = bx + $urandom_range(0, 6);
      ys[i] = by + $urandom_range(0, 6);
      add_load(i, xs[i], ys[i], $urandom, $urandom, $urandom);
    end
    w = ((xs[0] > xs[1] ? xs[0] : xs[1]) > xs[2] ? (xs[0] > xs[1] ? xs[0] : xs[1]) : xs[2])
      - ((xs[0] < xs[1] ? xs[0] : xs[1]) < xs[2] ? (xs[0] < xs[1] ? xs[0] : xs[1]) : xs[2]);
    h = ((ys[0] > ys[1] ? ys[0] : ys[1]) > ys[2] ? (ys[0] > ys[1] ? ys[0] : ys[1]) : ys[2])
      - ((ys[0] < ys[1] ? ys[0] : ys[1]) < ys[2] ? (ys[0] < ys[1] ? ys[0] : ys[1]) : ys[2]);
    n = w * h;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(0, n);          // cut short by the next load
      1: n = n + $urandom_range(1, 3);      // trailing idle steps
      default: ;
    endcase
    add_steps(n);
    n_tri++;
  endtask

  initial begin
    // Directed: idle step, unused slot, extremes, empty box, abort
    add_steps(1);
    add_load(SLOT_UNUSED, 1023, 1023, 2047, 1023, 1023);
    add_load(0, 1023, 1023, 2047, 1023, 1023);
    add_load(1, 1019, 1023, -2048, 0, 1023);
    add_load(2, 1023, 1019, 0, 1023, 0);
    add_steps(16);
    add_load(0, 0, 0, -2048, 0, 0);
    add_load(1, 3, 0, -2048, 0, 0);
    add_load(2, 0, 3, -2048, 0, 0);
    add_steps(9);
    add_load(2, 6, 6, 2047, 1023, 1023);     // reload far corner over the same area
    add_steps(36);
    add_load(2, 2, 0, 5, 5, 5);              // flat box: no walk
    add_steps(1);
    add_load(0, 10, 10, 100, 200, 300);
    add_load(1, 14, 10, 100, 200, 300);
    add_load(2, 10, 14, 100, 200, 300);
    add_steps(5);
    add_load(0, 11, 10, 2047, 1023, 1023);   // load mid-walk ends it
    add_steps(2);
    while (pending_beats.size() < NUM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) add_load($urandom_range(0, 3), $urandom, $urandom,
                                               $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 19) == 0) add_steps($urandom_range(1, 3));
      else add_triangle();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("MISMATCH %0d pixel beats never arrived", expected_pixels.size());
      errors++;
    end
    $display("Covered %0d input beats over %0d random triangles plus directed cases;",
             n_in, n_tri);
    $display("checked %0d candidate beats, %0d of them drawn.", n_out, n_drawn);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
